// ===== design/kmd_pkg.sv =====
// Shared types and constants for the key matrix debouncer.
// Holds configuration defaults, register indexes and the structs passed between modules.
// No dependencies.
package kmd_pkg;

    localparam int KMD_KEYS_MAX   = 64;
    localparam int KMD_DIM_W      = 5;
    localparam int KMD_DEB_W      = 16;
    localparam int KMD_TIME_W     = 32;
    localparam int KMD_LIMIT_W    = 2 * KMD_DIM_W;
    localparam int KMD_CFG_IDX_W  = 2;

    localparam logic [KMD_DIM_W-1:0] KMD_ROWS_RESET = 5'd8;
    localparam logic [KMD_DIM_W-1:0] KMD_COLS_RESET = 5'd8;
    localparam logic [KMD_DEB_W-1:0] KMD_DEB_RESET  = 16'd20;

    typedef enum logic [KMD_CFG_IDX_W-1:0] {
        CFG_NUM_ROWS    = 2'd0,
        CFG_NUM_COLS    = 2'd1,
        CFG_DEBOUNCE_MS = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [KMD_DIM_W-1:0] num_rows;
        logic [KMD_DIM_W-1:0] num_cols;
        logic [KMD_DEB_W-1:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic pressed;
        logic rose;
        logic fell;
        logic changed;
    } t_key_status;

endpackage

// ===== design/kmd_cfg_regs.sv =====
// Configuration register file of the key matrix debouncer.
// Holds row count, column count and debounce interval; uses kmd_pkg.
module kmd_cfg_regs import kmd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [KMD_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KMD_DEB_W-1:0]     i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_NUM_ROWS:    n_cfg.num_rows    = i_cfg_data[KMD_DIM_W-1:0];
                CFG_NUM_COLS:    n_cfg.num_cols    = i_cfg_data[KMD_DIM_W-1:0];
                CFG_DEBOUNCE_MS: n_cfg.debounce_ms = i_cfg_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_rows    <= KMD_ROWS_RESET;
            r_cfg.num_cols    <= KMD_COLS_RESET;
            r_cfg.debounce_ms <= KMD_DEB_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/kmd_key_lane.sv =====
// Debounce state and lockout timer of one key.
// Computes the post-scan state of the key and stores it on a transfer; uses kmd_pkg.
module kmd_key_lane import kmd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_update,
    input  logic                  i_scanned,
    input  logic                  i_level,
    input  logic [KMD_TIME_W-1:0] i_now_ms,
    input  logic [KMD_DEB_W-1:0]  i_debounce_ms,
    output t_key_status           o_status
);

    logic                  r_pressed;
    logic                  r_rose;
    logic                  r_fell;
    logic [KMD_TIME_W-1:0] r_time;

    logic                  n_pressed;
    logic                  n_rose;
    logic                  n_fell;
    logic [KMD_TIME_W-1:0] n_time;

    logic                  raw;
    logic [KMD_TIME_W-1:0] elapsed;
    logic                  unlocked;
    logic                  changed;

    assign raw      = ~i_level;
    assign elapsed  = i_now_ms - r_time;
    assign unlocked = elapsed >= {{(KMD_TIME_W-KMD_DEB_W){1'b0}}, i_debounce_ms};

    always_comb begin
        n_pressed = r_pressed;
        n_rose    = r_rose;
        n_fell    = r_fell;
        n_time    = r_time;
        changed   = 1'b0;
        if (i_scanned) begin
            if (raw != r_pressed) begin
                if (unlocked) begin
                    n_pressed = raw;
                    n_rose    = raw;
                    n_fell    = ~raw;
                    n_time    = i_now_ms;
                    changed   = 1'b1;
                end
            end else begin
                n_rose = 1'b0;
                n_fell = 1'b0;
            end
        end
    end

    assign o_status.pressed = n_pressed;
    assign o_status.rose    = n_rose;
    assign o_status.fell    = n_fell;
    assign o_status.changed = changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
            r_rose    <= 1'b0;
            r_fell    <= 1'b0;
            r_time    <= '0;
        end else if (i_update) begin
            r_pressed <= n_pressed;
            r_rose    <= n_rose;
            r_fell    <= n_fell;
            r_time    <= n_time;
        end
    end

endmodule

// ===== design/key_matrix_debouncer_unit.sv =====
// Key matrix debouncer: per-key lockout debounce over one full matrix scan per transfer.
// One scan is accepted every cycle while the output is not stalled.
// The input register feeds one lane per key, whose result lands in the output register.
// Reset (synchronous, active low) clears all key state and loads the default configuration.
// Depends on kmd_pkg, kmd_cfg_regs and kmd_key_lane.
module key_matrix_debouncer_unit import kmd_pkg::*; #(
    parameter int NUM_KEYS = KMD_KEYS_MAX
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [31:0]              i_now_ms,
    input  logic [63:0]              i_key_levels,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [63:0]              o_changed_mask,
    output logic [63:0]              o_pressed_mask,
    output logic [63:0]              o_rise_mask,
    output logic [63:0]              o_fall_mask,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [KMD_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KMD_DEB_W-1:0]     i_cfg_data
);

    t_cfg cfg;

    logic                  r_in_valid;
    logic [KMD_TIME_W-1:0] r_now_ms;
    logic [63:0]           r_levels;
    logic                  r_out_valid;
    logic [63:0]           r_changed;
    logic [63:0]           r_pressed;
    logic [63:0]           r_rise;
    logic [63:0]           r_fall;

    logic                   advance;
    logic                   in_xfer;
    logic [KMD_LIMIT_W-1:0] scan_limit;
    logic [63:0]            changed;
    logic [63:0]            pressed;
    logic [63:0]            rise;
    logic [63:0]            fall;

    kmd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // A key is scanned exactly when its index lies below rows times columns.
    assign scan_limit = {{KMD_DIM_W{1'b0}}, cfg.num_rows} * {{KMD_DIM_W{1'b0}}, cfg.num_cols};

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    for (genvar k = 0; k < 64; k++) begin : g_key
        if (k < NUM_KEYS) begin : g_lane
            t_key_status status;
            logic        scanned;

            assign scanned = KMD_LIMIT_W'(k) < scan_limit;

            kmd_key_lane u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_update      (advance),
                .i_scanned     (scanned),
                .i_level       (r_levels[k]),
                .i_now_ms      (r_now_ms),
                .i_debounce_ms (cfg.debounce_ms),
                .o_status      (status)
            );

            assign changed[k] = status.changed;
            assign pressed[k] = status.pressed;
            assign rise[k]    = status.rose;
            assign fall[k]    = status.fell;
        end else begin : g_none
            assign changed[k] = 1'b0;
            assign pressed[k] = 1'b0;
            assign rise[k]    = 1'b0;
            assign fall[k]    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_now_ms <= i_now_ms;
            r_levels <= i_key_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_changed <= changed;
            r_pressed <= pressed;
            r_rise    <= rise;
            r_fall    <= fall;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_changed_mask = r_changed;
    assign o_pressed_mask = r_pressed;
    assign o_rise_mask    = r_rise;
    assign o_fall_mask    = r_fall;

endmodule
